// File: hdl/sspq_pkg.sv
package sspq_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// File: hdl/sspq_if.sv
interface sspq_req_if #(
    parameter int KEY_BITS    = 8,
    parameter int RECORD_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [KEY_BITS-1:0]    priority_req;
    logic [RECORD_BITS-1:0] record;

    modport source (output valid, output action, output priority_req, output record,
                    input ready);
    modport sink (input valid, input action, input priority_req, input record,
                  output ready);
endinterface

interface sspq_rsp_if #(
    parameter int KEY_BITS    = 8,
    parameter int RECORD_BITS = 32,
    parameter int CNT_BITS    = 5
);
    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [KEY_BITS-1:0]    out_priority;
    logic [RECORD_BITS-1:0] out_record;
    logic [CNT_BITS-1:0]    count;
    logic                   is_empty;

    modport source (output valid, output ok, output out_priority, output out_record,
                    output count, output is_empty, input ready);
    modport sink (input valid, input ok, input out_priority, input out_record,
                  input count, input is_empty, output ready);
endinterface

// File: hdl/stable_sorted_priority_queue.sv
// channel | dir | fields
// req     | in  | action, priority_req, record
// rsp     | out | ok, out_priority, out_record, count, is_empty
//
// each transaction has a capture step for the request and an execute step for the
// parallel compare and shift across all slots of the sorted register list
// a new request is taken while the previous result still waits on rsp
// the execute cycle holds while the result register is occupied and not taken
// reset clears the entry count and handshake state only

module stable_sorted_priority_queue #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 8,
    parameter int RECORD_BITS = 32
) (
    input logic        clk,
    input logic        rst_n,
    sspq_req_if.sink   req,
    sspq_rsp_if.source rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sspq_pkg::cmd_t cmd;

    sspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sspq_datapath #(
        .DEPTH       (DEPTH),
        .KEY_BITS    (KEY_BITS),
        .RECORD_BITS (RECORD_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (req.action),
        .priority_req (req.priority_req),
        .record       (req.record),
        .ok           (rsp.ok),
        .out_priority (rsp.out_priority),
        .out_record   (rsp.out_record),
        .count        (rsp.count),
        .is_empty     (rsp.is_empty)
    );

endmodule

// File: hdl/sspq_ctrl.sv
module sspq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sspq_pkg::cmd_t    cmd
);

    sspq_pkg::state_t state_reg;
    sspq_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sspq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sspq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sspq_pkg::ST_EXEC;
                end
            end
            sspq_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = sspq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sspq_pkg::ST_IDLE;
            end
        endcase

        priority if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hdl/sspq_datapath.sv
module sspq_datapath #(
    parameter int DEPTH       = 16,
    parameter int KEY_BITS    = 8,
    parameter int RECORD_BITS = 32,
    parameter int CNT_BITS    = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sspq_pkg::cmd_t         cmd,
    input  logic [1:0]             action,
    input  logic [KEY_BITS-1:0]    priority_req,
    input  logic [RECORD_BITS-1:0] record,
    output logic                   ok,
    output logic [KEY_BITS-1:0]    out_priority,
    output logic [RECORD_BITS-1:0] out_record,
    output logic [CNT_BITS-1:0]    count,
    output logic                   is_empty
);

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    logic [1:0]             act_reg;
    logic [KEY_BITS-1:0]    req_key_reg;
    logic [RECORD_BITS-1:0] req_rec_reg;

    logic [KEY_BITS-1:0]    key_reg [DEPTH];
    logic [RECORD_BITS-1:0] rec_reg [DEPTH];
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;

    logic                   ok_reg;
    logic [KEY_BITS-1:0]    opri_reg;
    logic [RECORD_BITS-1:0] orec_reg;
    logic [CNT_BITS-1:0]    ocnt_reg;
    logic                   oempty_reg;

    logic [DEPTH-1:0]       gt;
    logic                   ins_en;
    logic                   rem_en;
    logic                   clr_en;
    logic                   ok_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            req_key_reg <= priority_req;
            req_rec_reg <= record;
        end
    end

    // slots above the new key, monotone because the list is sorted
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_BITS'(i) < count_reg) && (key_reg[i] > req_key_reg);
        end
    end

    always_comb
    begin
        ins_en     = (act_reg == sspq_pkg::ACT_INSERT) && (count_reg != FULL_COUNT);
        rem_en     = (act_reg == sspq_pkg::ACT_REMOVE) && (count_reg != '0);
        clr_en     = (act_reg == sspq_pkg::ACT_CLEAR);
        ok_next    = ins_en || rem_en || clr_en;
        priority if (clr_en)
            count_next = '0;
        else if (ins_en)
            count_next = count_reg + 1'b1;
        else if (rem_en)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        logic shift_in;
        logic place;
        logic pull;
        if (g == 0)
        begin : g_first
            assign shift_in = 1'b0;
        end
        else
        begin : g_rest
            assign shift_in = gt[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign pull = 1'b0;
        end
        else
        begin : g_inner
            assign pull = 1'b1;
        end
        assign place = !shift_in && (gt[g] || (CNT_BITS'(g) == count_reg));

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
            begin
                priority if (ins_en && shift_in)
                begin
                    key_reg[g] <= key_reg[(g == 0) ? 0 : g - 1];
                    rec_reg[g] <= rec_reg[(g == 0) ? 0 : g - 1];
                end
                else if (ins_en && place)
                begin
                    key_reg[g] <= req_key_reg;
                    rec_reg[g] <= req_rec_reg;
                end
                else if (rem_en && pull)
                begin
                    key_reg[g] <= key_reg[(g == DEPTH - 1) ? g : g + 1];
                    rec_reg[g] <= rec_reg[(g == DEPTH - 1) ? g : g + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg     <= ok_next;
            opri_reg   <= rem_en ? key_reg[0] : '0;
            orec_reg   <= rem_en ? rec_reg[0] : '0;
            ocnt_reg   <= count_next;
            oempty_reg <= (count_next == '0);
        end
    end

    assign ok           = ok_reg;
    assign out_priority = opri_reg;
    assign out_record   = orec_reg;
    assign count        = ocnt_reg;
    assign is_empty     = oempty_reg;

endmodule
